>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // request codes
    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;   // capture the incoming request
        logic execute;    // update ring indices and access the store
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    // (a + b) mod DEPTH, for a and b both below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(DEPTH)) begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one request: capture, execute, hand result to output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output deq_pkg::t_dp_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register occupancy
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, front index, count and result registers.
// ----------------------------------------------------------------------------
module deq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  deq_pkg::t_dp_cmd              i_cmd,
    input  logic [1:0]                    i_op,
    input  logic signed [deq_pkg::WORD_W-1:0] i_value,
    output logic signed [deq_pkg::WORD_W-1:0] o_popped,
    output logic [1:0]                    o_status,
    output logic [deq_pkg::CNT_W-1:0]     o_fill
);
    import deq_pkg::*;

    // request registers
    t_op               r_op;
    logic [WORD_W-1:0] r_value;

    // ring state
    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;

    // store
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // pending result
    t_status           r_status;
    logic              r_pop_ok;

    // output register
    logic [WORD_W-1:0] r_out_popped;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_fill;

    logic              w_is_push, w_full, w_empty, w_ok;
    logic              w_wr_en, w_rd_en;
    logic [IDX_W-1:0]  w_wr_addr, w_rd_addr;
    logic [IDX_W-1:0]  w_front_dec, w_front_inc, w_cnt_idx, w_cnt_m1;
    t_status           w_status;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= t_op'(i_op);
            r_value <= i_value;
        end
    end

    // index arithmetic and request decode
    always_comb begin
        w_is_push   = (r_op == OP_PUSH_BACK) || (r_op == OP_PUSH_FRONT);
        w_full      = (r_count == CNT_W'(DEPTH));
        w_empty     = (r_count == '0);
        w_ok        = w_is_push ? !w_full : !w_empty;
        w_cnt_idx   = r_count[IDX_W-1:0];
        w_cnt_m1    = w_cnt_idx - 1'b1;
        w_front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
        w_front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

        w_wr_addr = r_front;
        w_rd_addr = r_front;
        n_front   = r_front;
        case (r_op)
            OP_PUSH_BACK: begin
                w_wr_addr = ring_add(r_front, w_cnt_idx);
            end
            OP_PUSH_FRONT: begin
                w_wr_addr = w_front_dec;
                n_front   = w_front_dec;
            end
            OP_POP_FRONT: begin
                w_rd_addr = r_front;
                n_front   = w_front_inc;
            end
            OP_POP_BACK: begin
                w_rd_addr = ring_add(r_front, w_cnt_m1);
            end
            default: begin
                n_front = r_front;
            end
        endcase

        n_count  = w_is_push ? r_count + 1'b1 : r_count - 1'b1;
        w_wr_en  = i_cmd.execute && w_ok && w_is_push;
        w_rd_en  = i_cmd.execute && w_ok && !w_is_push;

        if (w_ok) begin
            w_status = ST_DONE;
        end else if (w_is_push) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_EMPTY;
        end
    end

    // ring state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.execute && w_ok) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= w_status;
            r_pop_ok <= w_ok && !w_is_push;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_popped <= r_pop_ok ? r_rd_data : '0;
            r_out_status <= r_status;
            r_out_fill   <= r_count;
        end
    end

    assign o_popped = r_out_popped;
    assign o_status = r_out_status;
    assign o_fill   = r_out_fill;

endmodule

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a ring store.
// ----------------------------------------------------------------------------
// Each request (push back, push front, pop front, pop back) goes through
// these steps in order: the input transfer captures the request, the execute
// step updates the front index and count while the ring store is written or
// read, and the output step loads the registered read data into the output
// register. A new request is not taken while one is in flight: it is taken
// as soon as the previous one has reached the output register. If that
// result is still waiting, the new request is executed but then waits to
// load its result, and the input is held off until the waiting result is
// transferred. Every request yields one result: the popped word (zero unless
// a pop succeeded), a status (done, pop on empty, push on full) and the
// count held afterwards. Failed requests leave the contents unchanged. No
// clearing pass after reset.
module double_ended_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic signed [deq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [deq_pkg::WORD_W-1:0] o_popped,
    output logic [1:0]                        o_status,
    output logic [deq_pkg::CNT_W-1:0]         o_fill
);
    import deq_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd)
    );

    // ring store and result path
    deq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_popped (o_popped),
        .o_status (o_status),
        .o_fill   (o_fill)
    );

    // one request in flight: ready drops right after an input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a request was in flight");

    // count never exceeds the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill <= CNT_W'(DEPTH)))
        else $error("fill above depth");

    // a pop on empty returns zero and reports an empty store
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> ((o_popped == '0) && (o_fill == '0)))
        else $error("empty status with nonzero word or count");

    // a push on full leaves the store full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_fill == CNT_W'(DEPTH)))
        else $error("full status with count below depth");

endmodule
